### rtl/psched_pkg.sv
package psched_pkg;

  // Field widths of the job and result beats
  localparam int BURST_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int JOBNUM_W    = 7;
  localparam int TIME_W      = 22;
  localparam int MAX_JOBS_DEF = 64;

  // Bus widths: tdata packed from bit 0 up, padded to whole bytes
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 112;

  // One slot of the sorted chain
  typedef struct packed {
    logic                valid;
    logic [PRIO_W-1:0]   prio;
    logic [BURST_W-1:0]  burst;
    logic [JOBNUM_W-1:0] num;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t op;
    entry_t   job;
  } cell_ctrl_t;

endpackage

### rtl/psched_cell.sv
module psched_cell
  import psched_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     prev_ent,
  input  logic       prev_shift,
  input  entry_t     next_ent,
  output entry_t     ent,
  output logic       shift
);

  // This slot moves down when it is empty or holds a strictly larger value,
  // so equal priorities stay in arrival order
  assign shift = !ent.valid || (ent.prio > ctrl.job.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_HOLD: begin
          ent <= ent;
        end
        CELL_INSERT: begin
          if (shift) begin
            ent <= prev_shift ? prev_ent : ctrl.job;
          end
        end
        CELL_SHIFT: begin
          ent <= next_ent;
        end
        default: begin
          ent <= ent;
        end
      endcase
    end
  end

endmodule

### rtl/psched_div.sv
module psched_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, quot[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      quot <= num;
      rem  <= '0;
      cnt  <= CNT_W'(NUM_W);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quot <= {quot[NUM_W-2:0], ge};
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

### rtl/priority_schedule_timing.sv
// Non-preemptive priority scheduler for one batch of jobs.
//
// s_axis carries jobs: tdata holds burst and priority, tlast marks the final
// job of the batch. Jobs load one per cycle into a sorted chain of cells; a
// job that arrives with MAX_JOBS already stored is dropped, but its tlast
// still closes the batch.
// After the final job the block stops taking beats and runs:
//   a pass over the chain summing waits;
//   two restoring dividers for the means;
//   emission of one result per job in schedule order, one per cycle,
//   except while the receiver stalls.
// m_axis carries results; tlast marks the last result of the batch. Results
// leave through an output register: a stalled receiver simply holds the beat
// and pauses the chain, nothing is lost. Loading resumes once the last result
// is in the output register.
// Reset empties the chain, clears the job count and drops any pending
// result; s_axis_tready is high right after reset.
module priority_schedule_timing
  import psched_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // job beat
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] burst, [23:16] priority_req
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic                s_axis_tlast,
  // result beat
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [6:0] job_number, [22:7] job_burst, [44:23] wait_time,
  // [66:45] turnaround, [88:67] avg_wait, [110:89] avg_turnaround, [111] zero
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int RC_W  = $clog2(MAX_JOBS);
  localparam int ACC_W = BURST_W + CNT_W;
  localparam int SUM_W = BURST_W + 2 * CNT_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SUM,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    job_count;
  logic [CNT_W-1:0]    emit_idx;
  logic [RC_W-1:0]     rot_cnt;
  logic [ACC_W-1:0]    acc;
  logic [SUM_W-1:0]    sum_w;
  logic [TIME_W-1:0]   avg_w;
  logic [TIME_W-1:0]   avg_t;
  logic [JOBNUM_W-1:0] m_num;
  logic [BURST_W-1:0]  m_burst;
  logic [TIME_W-1:0]   m_wait;
  logic [TIME_W-1:0]   m_turn;

  cell_ctrl_t ctrl;
  entry_t     ents   [MAX_JOBS];
  entry_t     prev_e [MAX_JOBS];
  entry_t     next_e [MAX_JOBS];
  logic       shifts [MAX_JOBS];
  logic       prev_s [MAX_JOBS];
  entry_t     tail_feed;

  logic             in_beat;
  logic             load_out;
  logic             div_start;
  logic [SUM_W-1:0] q_w;
  logic [SUM_W-1:0] q_t;
  logic             done_w;
  logic             done_t;
  logic [SUM_W-1:0] sum_t;

  assign s_axis_tready = (state == S_LOAD);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state == S_EMIT) && (emit_idx != job_count) &&
                         (!m_axis_tvalid || m_axis_tready);
  assign div_start     = (state == S_START);
  assign sum_t         = sum_w + SUM_W'(acc);

  // Cell control: insert job beats unless full, rotate in sum, drain on emit
  always_comb begin
    ctrl.job.valid = 1'b1;
    ctrl.job.burst = s_axis_tdata[BURST_W-1:0];
    ctrl.job.prio  = s_axis_tdata[BURST_W+PRIO_W-1:BURST_W];
    ctrl.job.num   = JOBNUM_W'(job_count) + JOBNUM_W'(1);
    ctrl.op        = CELL_HOLD;
    if (in_beat && (job_count != CNT_W'(MAX_JOBS))) begin
      ctrl.op = CELL_INSERT;
    end else if ((state == S_SUM) || load_out) begin
      ctrl.op = CELL_SHIFT;
    end
  end

  // Summing pass rotates the chain back to its start; emission feeds empties
  always_comb begin
    tail_feed       = ents[0];
    tail_feed.valid = (state == S_SUM) && ents[0].valid;
  end

  // Chain of cells, head is cell 0
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_e[i] = ctrl.job;
      assign prev_s[i] = 1'b0;
    end else begin : g_body
      assign prev_e[i] = ents[i-1];
      assign prev_s[i] = shifts[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_tail
      assign next_e[i] = tail_feed;
    end else begin : g_inner
      assign next_e[i] = ents[i+1];
    end

    psched_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_ent   (prev_e[i]),
      .prev_shift (prev_s[i]),
      .next_ent   (next_e[i]),
      .ent        (ents[i]),
      .shift      (shifts[i])
    );
  end

  // Means of wait and turnaround
  psched_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div_w (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_w),
    .den   (job_count),
    .quot  (q_w),
    .done  (done_w)
  );

  psched_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div_t (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_t),
    .den   (job_count),
    .quot  (q_t),
    .done  (done_t)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      job_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Output beat: set when a result is loaded, cleared once taken
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (job_count != CNT_W'(MAX_JOBS)) begin
              job_count <= job_count + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              state   <= S_SUM;
              rot_cnt <= '0;
              acc     <= '0;
              sum_w   <= '0;
            end
          end
        end
        S_SUM: begin
          if (ents[0].valid) begin
            sum_w <= sum_w + SUM_W'(acc);
            acc   <= acc + ACC_W'(ents[0].burst);
          end
          rot_cnt <= rot_cnt + RC_W'(1);
          if (rot_cnt == RC_W'(MAX_JOBS - 1)) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (done_w && done_t) begin
            acc      <= '0;
            emit_idx <= '0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_idx == job_count) begin
            job_count <= '0;
            state     <= S_LOAD;
          end else if (load_out) begin
            m_num         <= ents[0].num;
            m_burst       <= ents[0].burst;
            m_wait        <= TIME_W'(acc);
            m_turn        <= TIME_W'(acc + ACC_W'(ents[0].burst));
            // means ride in the output register so a held beat stays intact
            avg_w         <= TIME_W'(q_w);
            avg_t         <= TIME_W'(q_t);
            m_axis_tlast  <= (emit_idx == job_count - CNT_W'(1));
            acc           <= acc + ACC_W'(ents[0].burst);
            emit_idx      <= emit_idx + CNT_W'(1);
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, avg_t, avg_w, m_turn, m_wait, m_burst, m_num};

endmodule

### rtl/psched_checker.sv
module psched_checker
  import psched_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // Closing job of a batch stops further loading
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("job accepted right after the closing job");

  // Mid-batch results keep the job port closed
  a_no_load_mid_batch: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
    else $error("job port open while results of the batch remain");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat pending after reset");

  // A stalled result beat holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result beat changed while stalled");

endmodule

bind priority_schedule_timing psched_checker u_psched_checker (.*);
